/* hw/rtl/plics_pkg.sv */
// ----------------------------------------------------------------------------
// plics_pkg
// Shared types and constants for the piecewise-linear inverse-CDF sampler.
// ----------------------------------------------------------------------------
package plics_pkg;

    localparam int WIDTH_W = 16;
    localparam int DENS_W  = 16;
    localparam int U_W     = 16;
    localparam int AREA_W  = 40;
    localparam int T_W     = AREA_W + U_W;
    localparam int ACC_W   = T_W + WIDTH_W;
    localparam int STEP_W  = 4;

    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_SAMPLE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_FEW  = 3'd1,
        ST_FULL = 3'd2,
        ST_DECR = 3'd3,
        ST_ZERO = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_MUL,
        S_LD_ADD,
        S_SM_MUL,
        S_SM_INIT,
        S_SM_SCAN,
        S_SM_SPAN,
        S_SM_NUM,
        S_SM_PMUL,
        S_SM_DIV
    } state_t;

    typedef struct packed {
        logic             sub;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             carry;
        logic             zero;
    } alu_rsp_t;

endpackage

/* hw/rtl/plics_ram.sv */
// ----------------------------------------------------------------------------
// plics_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plics_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/plics_alu.sv */
// ----------------------------------------------------------------------------
// plics_alu
// Shared add/subtract unit; carry high on subtract means a >= b.
// ----------------------------------------------------------------------------
module plics_alu (
    input  plics_pkg::alu_req_t req,
    output plics_pkg::alu_rsp_t rsp
);

    logic [plics_pkg::ACC_W:0] full_sum;

    assign full_sum = {1'b0, req.a}
                    + {1'b0, (req.sub ? ~req.b : req.b)}
                    + {{plics_pkg::ACC_W{1'b0}}, req.sub};

    assign rsp.sum   = full_sum[plics_pkg::ACC_W-1:0];
    assign rsp.carry = full_sum[plics_pkg::ACC_W];
    assign rsp.zero  = (full_sum[plics_pkg::ACC_W-1:0] == '0);

endmodule

/* hw/rtl/piecewise_linear_inverse_cdf_sampler_core.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_inverse_cdf_sampler_core
// Inverse-transform sampler over a piecewise-linear density table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. action selects
// clear, load one (width, density) point, or draw one sample from
// uniform_value. Every request yields one result: done pulses for one cycle
// with sampled_width and status. The receiver cannot stall; results are
// never held.
// Clear, unused action codes, a load into an empty table and every request
// that ends in an error status give done on the cycle after the request. Any
// other load runs 16 shift-add steps and then the accumulate before done. A
// sample runs 16 shift-add steps for u * total, a scan of one table entry per
// cycle up to the matched segment (index 1 .. TABLE_POINTS-1), two compare
// steps, 16 multiply steps and 16 restoring divide steps. A zero-area segment,
// or a draw at the lower end of its segment, ends after the first or second
// compare. Multiply, accumulate, compare and divide steps use one shared
// 72-bit add/subtract unit, one step per cycle, and the table scan reads one
// entry of each RAM per cycle.
// busy is high while a load or sample is in flight.
// Reset empties the table and clears the running density; the RAM contents
// are left as they are and are only read below the point count.
// ----------------------------------------------------------------------------
module piecewise_linear_inverse_cdf_sampler_core #(
    parameter int TABLE_POINTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] point_width,
    input  logic [15:0] point_density,
    input  logic [15:0] uniform_value,
    output logic        done,
    output logic [15:0] sampled_width,
    output logic [2:0]  status
);

    localparam int IW = $clog2(TABLE_POINTS);
    localparam int CW = $clog2(TABLE_POINTS + 1);

    plics_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]      pc_reg, pc_next;
    logic [15:0]        dl_reg, dl_next;
    logic               done_reg, done_next;

    logic [15:0]                      last_w_reg, last_w_next;
    logic [plics_pkg::AREA_W-1:0]     last_area_reg, last_area_next;
    logic [15:0]                      wnew_reg, wnew_next;
    logic [15:0]                      mplier_reg, mplier_next;
    logic [plics_pkg::T_W-1:0]        mcand_reg, mcand_next;
    logic [plics_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [plics_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]                    idx_reg, idx_next;
    logic [plics_pkg::AREA_W-1:0]     lo_reg, lo_next;
    logic [plics_pkg::AREA_W-1:0]     hi_reg, hi_next;
    logic [plics_pkg::AREA_W-1:0]     span_reg, span_next;
    logic [plics_pkg::AREA_W-1:0]     rem_reg, rem_next;
    logic [15:0]                      wlo_reg, wlo_next;
    logic [15:0]                      whi_reg, whi_next;
    logic [15:0]                      quo_reg, quo_next;
    logic [15:0]                      out_w_reg, out_w_next;
    plics_pkg::status_t               out_st_reg, out_st_next;

    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [IW-1:0]                 ram_raddr;
    logic [15:0]                   w_wdata, w_rdata;
    logic [plics_pkg::AREA_W-1:0]  c_wdata, c_rdata;

    plics_pkg::alu_req_t alu_req;
    plics_pkg::alu_rsp_t alu_rsp;

    logic accept;
    logic load_full;
    logic load_decr;
    logic few_points;
    logic area_zero;
    logic last_step;
    logic scan_last;
    logic alu_le;

    assign busy     = (state_reg != plics_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign done          = done_reg;
    assign sampled_width = out_w_reg;
    assign status        = out_st_reg;

    assign load_full  = (pc_reg == CW'(TABLE_POINTS));
    assign load_decr  = (pc_reg != '0) && (point_width < last_w_reg);
    assign few_points = (pc_reg < CW'(2));
    assign area_zero  = (last_area_reg == '0);
    assign last_step  = (cnt_reg == plics_pkg::LAST_STEP);
    assign scan_last  = ((CW'(idx_reg) + CW'(1)) == pc_reg);
    // hi <= lo or t <= lo * 2^16
    assign alu_le     = !alu_rsp.carry || alu_rsp.zero;

    plics_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_POINTS)
    ) u_width_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (w_wdata),
        .raddr (ram_raddr),
        .rdata (w_rdata)
    );

    plics_ram #(
        .WIDTH (plics_pkg::AREA_W),
        .DEPTH (TABLE_POINTS)
    ) u_area_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (c_wdata),
        .raddr (ram_raddr),
        .rdata (c_rdata)
    );

    plics_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // shared unit operand select
    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            plics_pkg::S_LD_MUL, plics_pkg::S_SM_MUL, plics_pkg::S_SM_PMUL:
            begin
                alu_req.a = {acc_reg[plics_pkg::ACC_W-2:0], 1'b0};
                alu_req.b = mplier_reg[15] ? plics_pkg::ACC_W'(mcand_reg) : '0;
            end
            plics_pkg::S_LD_ADD:
            begin
                alu_req.a = plics_pkg::ACC_W'(last_area_reg);
                alu_req.b = acc_reg;
            end
            plics_pkg::S_SM_SCAN:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = plics_pkg::ACC_W'({c_rdata, 16'b0});
                alu_req.b   = acc_reg;
            end
            plics_pkg::S_SM_SPAN:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = plics_pkg::ACC_W'(hi_reg);
                alu_req.b   = plics_pkg::ACC_W'(lo_reg);
            end
            plics_pkg::S_SM_NUM:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = acc_reg;
                alu_req.b   = plics_pkg::ACC_W'({lo_reg, 16'b0});
            end
            plics_pkg::S_SM_DIV:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = plics_pkg::ACC_W'({rem_reg, acc_reg[31]});
                alu_req.b   = plics_pkg::ACC_W'(span_reg);
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plics_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (action == plics_pkg::ACT_LOAD && !load_full && !load_decr
                        && pc_reg != '0)
                    begin
                        state_next = plics_pkg::S_LD_MUL;
                    end
                    else if (action == plics_pkg::ACT_SAMPLE && !few_points
                             && !area_zero)
                    begin
                        state_next = plics_pkg::S_SM_MUL;
                    end
                end
            end
            plics_pkg::S_LD_MUL:
            begin
                if (last_step)
                begin
                    state_next = plics_pkg::S_LD_ADD;
                end
            end
            plics_pkg::S_LD_ADD:
            begin
                state_next = plics_pkg::S_IDLE;
            end
            plics_pkg::S_SM_MUL:
            begin
                if (last_step)
                begin
                    state_next = plics_pkg::S_SM_INIT;
                end
            end
            plics_pkg::S_SM_INIT:
            begin
                state_next = plics_pkg::S_SM_SCAN;
            end
            plics_pkg::S_SM_SCAN:
            begin
                if (idx_reg != '0)
                begin
                    if (alu_rsp.carry)
                    begin
                        state_next = plics_pkg::S_SM_SPAN;
                    end
                    else if (scan_last)
                    begin
                        state_next = plics_pkg::S_IDLE;
                    end
                end
            end
            plics_pkg::S_SM_SPAN:
            begin
                state_next = alu_le ? plics_pkg::S_IDLE : plics_pkg::S_SM_NUM;
            end
            plics_pkg::S_SM_NUM:
            begin
                state_next = alu_le ? plics_pkg::S_IDLE : plics_pkg::S_SM_PMUL;
            end
            plics_pkg::S_SM_PMUL:
            begin
                if (last_step)
                begin
                    state_next = plics_pkg::S_SM_DIV;
                end
            end
            plics_pkg::S_SM_DIV:
            begin
                if (last_step)
                begin
                    state_next = plics_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plics_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pc_next        = pc_reg;
        dl_next        = dl_reg;
        done_next      = 1'b0;
        last_w_next    = last_w_reg;
        last_area_next = last_area_reg;
        wnew_next      = wnew_reg;
        mplier_next    = mplier_reg;
        mcand_next     = mcand_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        wlo_next       = wlo_reg;
        whi_next       = whi_reg;
        quo_next       = quo_reg;
        out_w_next     = out_w_reg;
        out_st_next    = out_st_reg;
        ram_we         = 1'b0;
        ram_waddr      = pc_reg[IW-1:0];
        ram_raddr      = idx_reg + IW'(1);
        w_wdata        = wnew_reg;
        c_wdata        = alu_rsp.sum[plics_pkg::AREA_W-1:0];

        case (state_reg)
            plics_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (plics_pkg::action_t'(action))
                        plics_pkg::ACT_CLEAR:
                        begin
                            pc_next     = '0;
                            dl_next     = '0;
                            done_next   = 1'b1;
                            out_w_next  = '0;
                            out_st_next = plics_pkg::ST_OK;
                        end
                        plics_pkg::ACT_LOAD:
                        begin
                            if (load_full)
                            begin
                                done_next   = 1'b1;
                                out_w_next  = '0;
                                out_st_next = plics_pkg::ST_FULL;
                            end
                            else if (load_decr)
                            begin
                                done_next   = 1'b1;
                                out_w_next  = '0;
                                out_st_next = plics_pkg::ST_DECR;
                            end
                            else if (pc_reg == '0)
                            begin
                                ram_we         = 1'b1;
                                w_wdata        = point_width;
                                c_wdata        = '0;
                                pc_next        = CW'(1);
                                dl_next        = point_density;
                                last_w_next    = point_width;
                                last_area_next = '0;
                                done_next      = 1'b1;
                                out_w_next     = '0;
                                out_st_next    = plics_pkg::ST_OK;
                            end
                            else
                            begin
                                dl_next     = point_density;
                                wnew_next   = point_width;
                                mplier_next = point_width - last_w_reg;
                                mcand_next  = plics_pkg::T_W'({1'b0, dl_reg}
                                                              + {1'b0, point_density});
                                acc_next    = '0;
                                cnt_next    = '0;
                            end
                        end
                        plics_pkg::ACT_SAMPLE:
                        begin
                            if (few_points)
                            begin
                                done_next   = 1'b1;
                                out_w_next  = '0;
                                out_st_next = plics_pkg::ST_FEW;
                            end
                            else if (area_zero)
                            begin
                                done_next   = 1'b1;
                                out_w_next  = '0;
                                out_st_next = plics_pkg::ST_ZERO;
                            end
                            else
                            begin
                                mplier_next = uniform_value;
                                mcand_next  = plics_pkg::T_W'(last_area_reg);
                                acc_next    = '0;
                                cnt_next    = '0;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            out_w_next  = '0;
                            out_st_next = plics_pkg::ST_OK;
                        end
                    endcase
                end
            end
            plics_pkg::S_LD_MUL, plics_pkg::S_SM_MUL:
            begin
                acc_next    = alu_rsp.sum;
                mplier_next = {mplier_reg[14:0], 1'b0};
                cnt_next    = cnt_reg + plics_pkg::STEP_W'(1);
            end
            plics_pkg::S_LD_ADD:
            begin
                ram_we         = 1'b1;
                last_area_next = alu_rsp.sum[plics_pkg::AREA_W-1:0];
                last_w_next    = wnew_reg;
                pc_next        = pc_reg + CW'(1);
                done_next      = 1'b1;
                out_w_next     = '0;
                out_st_next    = plics_pkg::ST_OK;
            end
            plics_pkg::S_SM_INIT:
            begin
                ram_raddr = '0;
                idx_next  = '0;
            end
            plics_pkg::S_SM_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    lo_next  = c_rdata;
                    wlo_next = w_rdata;
                    idx_next = IW'(1);
                end
                else if (alu_rsp.carry)
                begin
                    hi_next  = c_rdata;
                    whi_next = w_rdata;
                end
                else if (scan_last)
                begin
                    done_next   = 1'b1;
                    out_w_next  = last_w_reg;
                    out_st_next = plics_pkg::ST_OK;
                end
                else
                begin
                    lo_next  = c_rdata;
                    wlo_next = w_rdata;
                    idx_next = idx_reg + IW'(1);
                end
            end
            plics_pkg::S_SM_SPAN:
            begin
                if (alu_le)
                begin
                    done_next   = 1'b1;
                    out_w_next  = wlo_reg;
                    out_st_next = plics_pkg::ST_OK;
                end
                else
                begin
                    span_next = alu_rsp.sum[plics_pkg::AREA_W-1:0];
                end
            end
            plics_pkg::S_SM_NUM:
            begin
                if (alu_le)
                begin
                    done_next   = 1'b1;
                    out_w_next  = wlo_reg;
                    out_st_next = plics_pkg::ST_OK;
                end
                else
                begin
                    mcand_next  = alu_rsp.sum[plics_pkg::T_W-1:0];
                    mplier_next = whi_reg - wlo_reg;
                    acc_next    = '0;
                    cnt_next    = '0;
                end
            end
            plics_pkg::S_SM_PMUL:
            begin
                acc_next    = alu_rsp.sum;
                mplier_next = {mplier_reg[14:0], 1'b0};
                cnt_next    = cnt_reg + plics_pkg::STEP_W'(1);
                // dividend top bits seed the remainder
                rem_next    = alu_rsp.sum[plics_pkg::ACC_W-1:32];
            end
            plics_pkg::S_SM_DIV:
            begin
                rem_next = alu_rsp.carry ? alu_rsp.sum[plics_pkg::AREA_W-1:0]
                                         : {rem_reg[plics_pkg::AREA_W-2:0], acc_reg[31]};
                quo_next = {quo_reg[14:0], alu_rsp.carry};
                acc_next = {acc_reg[plics_pkg::ACC_W-2:0], 1'b0};
                cnt_next = cnt_reg + plics_pkg::STEP_W'(1);
                if (last_step)
                begin
                    done_next   = 1'b1;
                    out_w_next  = wlo_reg + {quo_reg[14:0], alu_rsp.carry};
                    out_st_next = plics_pkg::ST_OK;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plics_pkg::S_IDLE;
            pc_reg    <= '0;
            dl_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            dl_reg    <= dl_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_w_reg    <= last_w_next;
        last_area_reg <= last_area_next;
        wnew_reg      <= wnew_next;
        mplier_reg    <= mplier_next;
        mcand_reg     <= mcand_next;
        acc_reg       <= acc_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        span_reg      <= span_next;
        rem_reg       <= rem_next;
        wlo_reg       <= wlo_next;
        whi_reg       <= whi_next;
        quo_reg       <= quo_next;
        out_w_reg     <= out_w_next;
        out_st_reg    <= out_st_next;
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is in flight");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= CW'(TABLE_POINTS))
        else $error("point count beyond table depth");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_st_reg != plics_pkg::ST_OK) |-> (sampled_width == '0))
        else $error("nonzero width with error status");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == plics_pkg::ACT_CLEAR) |=> (done && pc_reg == '0))
        else $error("clear did not empty the table");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a request");
`endif

endmodule
